/* hdl/tpa_pkg.sv */
`default_nettype none

package tpa_pkg;

	// payload field widths
	localparam int LEN_W  = 27;
	localparam int PCT_W  = 7;
	localparam int CNT_W  = 32;
	localparam int TIER_W = 2;

	// stream data widths, padded to whole bytes
	localparam int IN_W  = 56;
	localparam int OUT_W = 128;

	// register port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_LOW_PCT = 1'b0;
	localparam logic REG_MED_PCT = 1'b1;

	// threshold values after reset
	localparam logic [PCT_W-1:0] RST_LOW_PCT = 7'd60;
	localparam logic [PCT_W-1:0] RST_MED_PCT = 7'd75;

	// tier capacities in bytes
	localparam int DEF_TIER_ONE_BYTES   = 1 << 20;
	localparam int DEF_TIER_TWO_BYTES   = 1 << 23;
	localparam int DEF_TIER_THREE_BYTES = 1 << 26;

	// tier codes
	localparam logic [TIER_W-1:0] TIER_ONE   = 2'd0;
	localparam logic [TIER_W-1:0] TIER_TWO   = 2'd1;
	localparam logic [TIER_W-1:0] TIER_THREE = 2'd2;
	localparam logic [TIER_W-1:0] TIER_NONE  = 2'd3;

endpackage

`default_nettype wire

/* hdl/tiered_placement_allocator.sv */
// A request passes the input, decision, pressure and output registers on its way to m_tdata.
// Throughput: one request per cycle unless m_tready stalls; the fill counters are updated
// in a single stage, so a request sees the state left by the one before it.
// Reset (arst_n low): fill counts, placement and miss counters cleared, thresholds 60 and 75,
// pipeline emptied.
`default_nettype none

module tiered_placement_allocator
	import tpa_pkg::*;
#(
	parameter int TIER_ONE_BYTES   = DEF_TIER_ONE_BYTES,
	parameter int TIER_TWO_BYTES   = DEF_TIER_TWO_BYTES,
	parameter int TIER_THREE_BYTES = DEF_TIER_THREE_BYTES
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// request stream
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// [26:0] source_length, [53:27] dest_limit, [55:54] zero
	input  wire logic [IN_W-1:0]   s_tdata,
	// result stream
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// [1:0] placed_tier, [28:2] write_offset, [55:29] placed_length,
	// [62:56] pressure_pct, [94:63] placement_count, [126:95] miss_count, [127] zero
	output logic [OUT_W-1:0]       m_tdata,
	// register port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	// sizes that follow from the capacities
	localparam longint unsigned CAP = longint'(TIER_ONE_BYTES) + longint'(TIER_TWO_BYTES)
		+ longint'(TIER_THREE_BYTES);
	localparam int T1_W  = $clog2(TIER_ONE_BYTES + 1);
	localparam int T2_W  = $clog2(TIER_TWO_BYTES + 1);
	localparam int T3_W  = $clog2(TIER_THREE_BYTES + 1);
	localparam int MX1_W = (T1_W > LEN_W) ? T1_W : LEN_W;
	localparam int MX2_W = (T2_W > MX1_W) ? T2_W : MX1_W;
	localparam int MX3_W = (T3_W > MX2_W) ? T3_W : MX2_W;
	localparam int FIT_W = MX3_W + 1;
	localparam int TOT_W = $clog2(CAP + 1);
	localparam int SC_W  = $clog2(100 * CAP + 1);
	localparam int LC_W  = $clog2(127 * CAP + 1);
	localparam int L100_W = LEN_W + PCT_W;
	localparam int THR_W = TOT_W + 1;
	localparam int THR_N = 1 << PCT_W;
	// pressure estimate: floor(total * RECIP / 2^RSH) is exact or one short
	localparam int RSH = 32;
	localparam longint unsigned RECIP = (64'd100 << RSH) / CAP;
	localparam int PROD_W = RSH + PCT_W + 1;

	// threshold table: smallest total that gives each pressure value
	logic [THR_W-1:0] thr [THR_N];
	for (genvar p = 0; p < THR_N; p++) begin : g_thr
		localparam longint unsigned THR_V = (64'(p) * CAP + 64'd99) / 64'd100;
		assign thr[p] = THR_W'(THR_V);
	end

	// configuration registers
	logic [PCT_W-1:0] low_pct_q, med_pct_q;
	logic [LC_W-1:0]  low_cap_q, med_cap_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_pct_q <= RST_LOW_PCT;
			med_pct_q <= RST_MED_PCT;
			low_cap_q <= LC_W'(64'(RST_LOW_PCT) * CAP);
			med_cap_q <= LC_W'(64'(RST_MED_PCT) * CAP);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_LOW_PCT: begin
					low_pct_q <= pwdata[PCT_W-1:0];
					low_cap_q <= LC_W'(pwdata[PCT_W-1:0]) * LC_W'(CAP);
				end
				REG_MED_PCT: begin
					med_pct_q <= pwdata[PCT_W-1:0];
					med_cap_q <= LC_W'(pwdata[PCT_W-1:0]) * LC_W'(CAP);
				end
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[2])
			REG_LOW_PCT: prdata = APB_DW'(low_pct_q);
			REG_MED_PCT: prdata = APB_DW'(med_pct_q);
			default:     prdata = '0;
		endcase
	end

	// stage handshake: a stage loads when it is empty or its beat moves on
	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4     = !v4_s4 || m_tready;
	assign rdy3     = !v3_s3 || rdy4;
	assign rdy2     = !v2_s2 || rdy3;
	assign rdy1     = !v1_s1 || rdy2;
	assign s_tready = rdy1;
	assign m_tvalid = v4_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (rdy1) v1_s1 <= s_tvalid;
			if (rdy2) v2_s2 <= v1_s1;
			if (rdy3) v3_s3 <= v2_s2;
			if (rdy4) v4_s4 <= v3_s3;
		end
	end

	// input stage: placement length and its scaled form
	logic [LEN_W-1:0]  in_src, in_lim, in_len;
	logic [LEN_W-1:0]  len_s1;
	logic [L100_W-1:0] len100_s1;
	logic              nz_s1;

	assign in_src = s_tdata[LEN_W-1:0];
	assign in_lim = s_tdata[2*LEN_W-1:LEN_W];
	assign in_len = (in_src == '0) ? '0 : ((in_src < in_lim) ? in_src : in_lim);

	always_ff @(posedge clk) begin
		if (rdy1) begin
			len_s1    <= in_len;
			nz_s1     <= (in_src != '0);
			len100_s1 <= (L100_W'(in_len) << 6) + (L100_W'(in_len) << 5)
				+ (L100_W'(in_len) << 2);
		end
	end

	// fill state; sc_q tracks 100 times the total fill
	logic [T1_W-1:0]  t1_used_q;
	logic [T2_W-1:0]  t2_used_q;
	logic [T3_W-1:0]  t3_used_q;
	logic [TOT_W-1:0] total_q;
	logic [SC_W-1:0]  sc_q;
	logic [CNT_W-1:0] place_cnt_q, miss_cnt_q;

	// tier choice
	logic              fit1, fit2, fit3, low_ok, med_ok, adv1;
	logic [TIER_W-1:0] tier_sel;

	assign adv1   = v1_s1 && rdy2;
	assign low_ok = LC_W'(sc_q) < low_cap_q;
	assign med_ok = LC_W'(sc_q) < med_cap_q;
	assign fit1   = (FIT_W'(t1_used_q) + FIT_W'(len_s1)) <= FIT_W'(TIER_ONE_BYTES);
	assign fit2   = (FIT_W'(t2_used_q) + FIT_W'(len_s1)) <= FIT_W'(TIER_TWO_BYTES);
	assign fit3   = (FIT_W'(t3_used_q) + FIT_W'(len_s1)) <= FIT_W'(TIER_THREE_BYTES);

	always_comb begin
		if (!nz_s1)             tier_sel = TIER_NONE;
		else if (low_ok && fit1) tier_sel = TIER_ONE;
		else if (med_ok && fit2) tier_sel = TIER_TWO;
		else if (fit3)           tier_sel = TIER_THREE;
		else                     tier_sel = TIER_NONE;
	end

	// counters after this request
	logic [CNT_W-1:0] place_nxt, miss_nxt;
	logic             placed, missed;

	assign placed    = (tier_sel != TIER_NONE);
	assign missed    = nz_s1 && !placed;
	assign place_nxt = (placed && place_cnt_q != '1) ? place_cnt_q + 1'b1 : place_cnt_q;
	assign miss_nxt  = (missed && miss_cnt_q != '1) ? miss_cnt_q + 1'b1 : miss_cnt_q;

	// state update as the request leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_used_q   <= '0;
			t2_used_q   <= '0;
			t3_used_q   <= '0;
			total_q     <= '0;
			sc_q        <= '0;
			place_cnt_q <= '0;
			miss_cnt_q  <= '0;
		end else if (adv1) begin
			place_cnt_q <= place_nxt;
			miss_cnt_q  <= miss_nxt;
			if (placed) begin
				total_q <= total_q + TOT_W'(len_s1);
				sc_q    <= sc_q + SC_W'(len100_s1);
			end
			case (tier_sel)
				TIER_ONE:   t1_used_q <= t1_used_q + T1_W'(len_s1);
				TIER_TWO:   t2_used_q <= t2_used_q + T2_W'(len_s1);
				TIER_THREE: t3_used_q <= t3_used_q + T3_W'(len_s1);
				default:    ;
			endcase
		end
	end

	// write offset is the chosen tier's old fill
	logic [LEN_W-1:0] offset_sel;

	always_comb begin
		case (tier_sel)
			TIER_ONE:   offset_sel = LEN_W'(t1_used_q);
			TIER_TWO:   offset_sel = LEN_W'(t2_used_q);
			TIER_THREE: offset_sel = LEN_W'(t3_used_q);
			default:    offset_sel = '0;
		endcase
	end

	// decision stage
	logic [TIER_W-1:0] tier_s2, tier_s3, tier_s4;
	logic [LEN_W-1:0]  offset_s2, offset_s3, offset_s4;
	logic [LEN_W-1:0]  len_s2, len_s3, len_s4;
	logic [TOT_W-1:0]  total_s2, total_s3;
	logic [CNT_W-1:0]  pc_s2, pc_s3, pc_s4;
	logic [CNT_W-1:0]  mc_s2, mc_s3, mc_s4;
	logic [PROD_W-1:0] prod_s3;
	logic [PCT_W-1:0]  pres_s4;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			tier_s2   <= tier_sel;
			offset_s2 <= offset_sel;
			len_s2    <= len_s1;
			total_s2  <= total_q;
			pc_s2     <= place_nxt;
			mc_s2     <= miss_nxt;
		end
	end

	// pressure estimate by reciprocal multiply
	always_ff @(posedge clk) begin
		if (rdy3) begin
			tier_s3   <= tier_s2;
			offset_s3 <= offset_s2;
			len_s3    <= len_s2;
			total_s3  <= total_s2;
			pc_s3     <= pc_s2;
			mc_s3     <= mc_s2;
			prod_s3   <= PROD_W'(total_s2) * PROD_W'(RECIP);
		end
	end

	// estimate correction against the threshold table
	logic [PCT_W-1:0] pres_est, pres_up;
	logic             pres_inc;

	assign pres_est = prod_s3[RSH +: PCT_W];
	assign pres_up  = pres_est + 1'b1;
	assign pres_inc = THR_W'(total_s3) >= thr[pres_up];

	// output register
	always_ff @(posedge clk) begin
		if (rdy4) begin
			tier_s4   <= tier_s3;
			offset_s4 <= offset_s3;
			len_s4    <= len_s3;
			pc_s4     <= pc_s3;
			mc_s4     <= mc_s3;
			pres_s4   <= pres_inc ? pres_up : pres_est;
		end
	end

	assign m_tdata = {1'b0, mc_s4, pc_s4, pres_s4, len_s4, offset_s4, tier_s4};

endmodule

`default_nettype wire
